@@ hdl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the winding-number test
// Coordinate, product and count widths, and the stage records passed
// between the entry, product and accumulate stages.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  localparam int FIELD_BITS   = 16;
  localparam int COORD_BITS   = 16;
  localparam int MAX_VERTICES = 4096;
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 2);
  localparam int ACC_BITS     = 13;

  typedef logic signed [FIELD_BITS-1:0]   field_t;
  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [COORD_BITS:0]     diff_t;
  typedef logic signed [2*COORD_BITS+1:0] prod_t;
  typedef logic signed [2*COORD_BITS+2:0] orient_t;
  typedef logic signed [ACC_BITS-1:0]     acc_t;
  typedef logic [CNT_BITS-1:0]            count_t;

  localparam acc_t ACC_MAX = acc_t'((1 << (ACC_BITS - 1)) - 1);
  localparam acc_t ACC_MIN = acc_t'(-(1 << (ACC_BITS - 1)));

  // one edge, a -> b
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } edge_t;

  // entry stage record: query point plus the open edge and the closing edge, each with an enable
  typedef struct packed {
    coord_t qx;
    coord_t qy;
    edge_t  e0;
    logic   e0_en;
    edge_t  e1;
    logic   e1_en;
    logic   last;
    logic   ovf;
  } s1_t;

  // per-edge cross product terms and flags
  typedef struct packed {
    logic  en;
    prod_t p0;
    prod_t p1;
    logic  in_box;
    logic  up;
    logic  down;
  } edge_term_t;

  // product stage record
  typedef struct packed {
    edge_term_t t0;
    edge_term_t t1;
    logic       last;
    logic       ovf;
  } s2_t;

  typedef struct packed {
    acc_t acc;
    logic hit;
  } tally_t;

endpackage

`default_nettype wire

@@ hdl/point_in_polygon_winding_number.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_winding_number: streaming winding-number polygon test
// Vertices arrive in order with the query point; one result per polygon.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  vertex   | vertex_valid / vertex_stall | query_x/y, vertex_x/y, last_vertex
//  result   | result_valid / result_stall | inside_res, on_boundary,
//           |                             | winding_count, vertex_overflow
//
// One vertex per cycle unless vertex_stall is set; three register stages
// (entry, product, accumulate) carry the last vertex to its result.
// The two 17x17 orientation products per edge set the product stage depth.
// Reset clears the stage valid flags, the count and the polygon state.
// A stalled result holds only items that close a polygon; other vertices
// keep flowing into the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_winding_number
  import pip_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  field_t query_x,
  input  field_t query_y,
  input  field_t vertex_x,
  input  field_t vertex_y,
  input  logic   last_vertex,
  input  logic   vertex_valid,
  output logic   vertex_stall,
  output logic   inside_res,
  output logic   on_boundary,
  output acc_t   winding_count,
  output logic   vertex_overflow,
  output logic   result_valid,
  input  logic   result_stall
);

  s1_t  s1;
  s2_t  s2;
  logic s1_valid, s1_take;
  logic s2_valid, s2_take;

  pip_entry u_entry (
    .clk          (clk),
    .rst          (rst),
    .query_x      (query_x),
    .query_y      (query_y),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .last_vertex  (last_vertex),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .s1           (s1),
    .s1_valid     (s1_valid),
    .s1_take      (s1_take)
  );

  pip_prod u_prod (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_take  (s2_take)
  );

  pip_accum u_accum (
    .clk             (clk),
    .rst             (rst),
    .s2              (s2),
    .s2_valid        (s2_valid),
    .s2_take         (s2_take),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .inside_res      (inside_res),
    .on_boundary     (on_boundary),
    .winding_count   (winding_count),
    .vertex_overflow (vertex_overflow)
  );

  // a new result comes only from a closing item in the product stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s2_valid) && $past(s2.last))
    else $error("result without closing item");

  // an empty entry stage never backs up the vertex side
  a_entry_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !vertex_stall)
    else $error("stall with empty entry stage");

  // an entry item not passed on stays in place
  a_entry_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_take |=> s1_valid && $stable(s1))
    else $error("entry item lost");

  // the result side only blocks items that close a polygon
  a_open_flow: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2.last |-> s2_take)
    else $error("open edge held by result side");

endmodule

`default_nettype wire

@@ hdl/pip_entry.sv @@
// ----------------------------------------------------------------------------
// pip_entry: input register and polygon vertex tracking
// Captures each vertex, pairs it with the previous and first vertex to
// form the open edge and the closing edge, and counts vertices.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_entry
  import pip_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  field_t query_x,
  input  field_t query_y,
  input  field_t vertex_x,
  input  field_t vertex_y,
  input  logic   last_vertex,
  input  logic   vertex_valid,
  output logic   vertex_stall,
  output s1_t    s1,
  output logic   s1_valid,
  input  logic   s1_take
);

  coord_t first_vx, first_vy, prev_vx, prev_vy;
  logic   have_first;
  count_t vertex_counter;

  coord_t qx, qy, vx, vy;
  count_t count_next;
  logic   in_xfer;

  assign qx = coord_t'(query_x[COORD_BITS-1:0]);
  assign qy = coord_t'(query_y[COORD_BITS-1:0]);
  assign vx = coord_t'(vertex_x[COORD_BITS-1:0]);
  assign vy = coord_t'(vertex_y[COORD_BITS-1:0]);

  assign vertex_stall = s1_valid && !s1_take;
  assign in_xfer      = vertex_valid && !vertex_stall;

  // saturates one past the limit
  assign count_next = (vertex_counter <= count_t'(MAX_VERTICES)) ?
                      vertex_counter + count_t'(1) : vertex_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      have_first     <= 1'b0;
      vertex_counter <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
      if (in_xfer) begin
        if (last_vertex) begin
          have_first     <= 1'b0;
          vertex_counter <= '0;
        end else begin
          have_first     <= 1'b1;
          vertex_counter <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      prev_vx <= vx;
      prev_vy <= vy;
      if (!have_first) begin
        first_vx <= vx;
        first_vy <= vy;
      end
      s1.qx    <= qx;
      s1.qy    <= qy;
      s1.e0    <= '{ax: prev_vx, ay: prev_vy, bx: vx, by: vy};
      s1.e0_en <= have_first;
      // closing edge; a lone vertex closes onto itself
      s1.e1    <= have_first ? edge_t'{ax: vx, ay: vy, bx: first_vx, by: first_vy}
                             : edge_t'{ax: vx, ay: vy, bx: vx, by: vy};
      s1.e1_en <= last_vertex;
      s1.last  <= last_vertex;
      s1.ovf   <= count_next > count_t'(MAX_VERTICES);
    end
  end

endmodule

`default_nettype wire

@@ hdl/pip_prod.sv @@
// ----------------------------------------------------------------------------
// pip_prod: cross product stage
// Forms the two orientation products, the bounding box test and the
// crossing direction for both edges of an item and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_prod
  import pip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  s1_t  s1,
  input  logic s1_valid,
  output logic s1_take,
  output s2_t  s2,
  output logic s2_valid,
  input  logic s2_take
);

  function automatic edge_term_t edge_eval(edge_t e, logic en, coord_t qx, coord_t qy);
    diff_t      dbx, dby, dqx, dqy;
    prod_t      p0, p1;
    logic       box_x, box_y;
    edge_term_t t;
    dbx = diff_t'(e.bx) - diff_t'(e.ax);
    dby = diff_t'(e.by) - diff_t'(e.ay);
    dqx = diff_t'(qx) - diff_t'(e.ax);
    dqy = diff_t'(qy) - diff_t'(e.ay);
    p0  = dbx * dqy;
    p1  = dby * dqx;
    box_x = (e.ax <= e.bx) ? (qx >= e.ax && qx <= e.bx) : (qx >= e.bx && qx <= e.ax);
    box_y = (e.ay <= e.by) ? (qy >= e.ay && qy <= e.by) : (qy >= e.by && qy <= e.ay);
    t.en     = en;
    t.p0     = p0;
    t.p1     = p1;
    t.in_box = box_x && box_y;
    t.up     = (e.ay <= qy) && (e.by > qy);
    t.down   = (e.ay > qy) && (e.by <= qy);
    return t;
  endfunction

  assign s1_take = s1_valid && (!s2_valid || s2_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_take) begin
      s2_valid <= 1'b1;
    end else if (s2_take) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2.t0   <= edge_eval(s1.e0, s1.e0_en, s1.qx, s1.qy);
      s2.t1   <= edge_eval(s1.e1, s1.e1_en, s1.qx, s1.qy);
      s2.last <= s1.last;
      s2.ovf  <= s1.ovf;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pip_accum.sv @@
// ----------------------------------------------------------------------------
// pip_accum: winding count accumulator and result register
// Resolves the sign of each orientation, updates the saturating count and
// the sticky boundary flag, and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_accum
  import pip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  s2_t  s2,
  input  logic s2_valid,
  output logic s2_take,
  output logic result_valid,
  input  logic result_stall,
  output logic inside_res,
  output logic on_boundary,
  output acc_t winding_count,
  output logic vertex_overflow
);

  function automatic tally_t edge_tally(tally_t cur, edge_term_t t);
    prod_t   p0, p1;
    orient_t o;
    tally_t  r;
    r  = cur;
    p0 = t.p0;
    p1 = t.p1;
    o  = orient_t'(p0) - orient_t'(p1);
    if (t.en) begin
      if (t.in_box && o == '0) begin
        r.hit = 1'b1;
      end else if (t.up && o > 0 && cur.acc < ACC_MAX) begin
        r.acc = cur.acc + acc_t'(1);
      end else if (t.down && o < 0 && cur.acc > ACC_MIN) begin
        r.acc = cur.acc - acc_t'(1);
      end
    end
    return r;
  endfunction

  acc_t   winding_acc;
  logic   boundary_hit;
  tally_t mid, fin;
  logic   out_ready;

  assign out_ready = !result_valid || !result_stall;
  // items that close no polygon never wait on the result side
  assign s2_take   = s2_valid && (!s2.last || out_ready);

  assign mid = edge_tally('{acc: winding_acc, hit: boundary_hit}, s2.t0);
  assign fin = edge_tally(mid, s2.t1);

  always_ff @(posedge clk) begin
    if (rst) begin
      winding_acc  <= '0;
      boundary_hit <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s2_take) begin
        if (s2.last) begin
          winding_acc  <= '0;
          boundary_hit <= 1'b0;
        end else begin
          winding_acc  <= fin.acc;
          boundary_hit <= fin.hit;
        end
      end
      if (s2_take && s2.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s2.last) begin
      inside_res      <= fin.hit || (fin.acc != '0);
      on_boundary     <= fin.hit;
      winding_count   <= fin.acc;
      vertex_overflow <= s2.ovf;
    end
  end

endmodule

`default_nettype wire
